>>> hw/rtl/utf8_sentence_segmenter_assert.svh
// assertion macros used by the segmenter core rtl
`ifndef UTF8_SENTENCE_SEGMENTER_ASSERT_SVH
`define UTF8_SENTENCE_SEGMENTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define USEG_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("useg assertion failed");

// next-cycle implication, checked outside reset
`define USEG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("useg assertion failed");

`endif

>>> hw/rtl/utf8seg_pkg.sv
package utf8seg_pkg;

	localparam int POS_BITS = 16;
	localparam int FILL_BITS = 7;
	localparam int START_BITS = 16;

	localparam logic [FILL_BITS-1:0] MAX_CAP = 7'd120;
	localparam logic [FILL_BITS-1:0] FILL_LIMIT = 7'd127;
	localparam logic [FILL_BITS-1:0] MAX_LEN_RESET = 7'd120;

	// ascii codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_EXCL = 8'h21;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	// cjk punctuation byte sequences
	localparam logic [7:0] CJK_A_B0 = 8'hE3;
	localparam logic [7:0] CJK_A_B1 = 8'h80;
	localparam logic [7:0] CJK_STOP = 8'h82;
	localparam logic [7:0] CJK_B_B0 = 8'hEF;
	localparam logic [7:0] CJK_B_B1 = 8'hBC;
	localparam logic [7:0] CJK_EXCL = 8'h81;
	localparam logic [7:0] CJK_QUEST = 8'h9F;
	localparam logic [7:0] CJK_SEMI = 8'h9B;

	typedef struct packed {
		logic [7:0] data_byte;
		logic end_of_text;
	} in_item_t;

	typedef struct packed {
		logic segment_valid;
		logic [START_BITS-1:0] segment_start;
		logic [FILL_BITS-1:0] segment_length;
		logic text_done;
	} out_item_t;

endpackage

>>> hw/rtl/utf8_sentence_segmenter.sv
// channel  | dir | handshake              | payload
// input    | in  | in_valid / in_stall    | in_data (data_byte, end_of_text)
// result   | out | out_valid / out_stall  | out_data (segment_valid, start, length, done)
// config   | in  | cfg_we                 | cfg_wdata (max_segment_length)
//
// one byte per cycle unless a segment-closing byte waits on a full, stalled result register; a byte passes
// the input register, and its result is then loaded into the result register, around the segment logic
// arst_n clears all segment state, the byte position and the valid flags; max length resets to 120
// out_stall holds the result register; the input register keeps taking bytes that produce no result
module utf8_sentence_segmenter (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  utf8seg_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output utf8seg_pkg::out_item_t out_data,
	input  logic cfg_we,
	input  logic [utf8seg_pkg::FILL_BITS-1:0] cfg_wdata
);
	import utf8seg_pkg::*;

	logic valid_s1;
	in_item_t item_s1;
	out_item_t result;
	logic out_free;
	logic advance;
	logic has_result;

	// a byte in the input register moves on unless it closes a segment
	// while the result register is still full and stalled
	assign advance = valid_s1 && (!has_result || out_free);

	// input register, stalls only when the held byte cannot move on
	utf8seg_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_data  (in_data),
		.advance  (advance),
		.in_stall (in_stall),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// segment tracking, trimming and cut decision for the held byte
	utf8seg_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_s1    (item_s1),
		.fire       (advance),
		.has_result (has_result),
		.result     (result)
	);

	// result register, one transfer per closed segment or end of text
	utf8seg_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && has_result),
		.result    (result),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

>>> hw/rtl/utf8seg_in_stage.sv
module utf8seg_in_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  utf8seg_pkg::in_item_t in_data,
	input  logic advance,
	output logic in_stall,
	output logic valid_s1,
	output utf8seg_pkg::in_item_t item_s1
);
	import utf8seg_pkg::*;

	logic load;

	assign in_stall = valid_s1 && !advance;
	assign load = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_data;
		end
	end

endmodule

>>> hw/rtl/utf8seg_core.sv
`include "utf8_sentence_segmenter_assert.svh"

module utf8seg_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [utf8seg_pkg::FILL_BITS-1:0] cfg_wdata,
	input  utf8seg_pkg::in_item_t item_s1,
	input  logic fire,
	output logic has_result,
	output utf8seg_pkg::out_item_t result
);
	import utf8seg_pkg::*;

	logic [FILL_BITS-1:0] max_len_q;
	logic [POS_BITS-1:0] pos_q, origin_q;
	logic [FILL_BITS-1:0] fill_q, lead_ws_q, lead_sp_q, end_ws_q, end_sp_q;
	logic seen_ws_q, seen_sp_q;
	logic [15:0] recent_q;
	logic [1:0] pend_q;

	logic [7:0] b;
	logic last, ws, sp, sep, cut, spaces_only, close;
	logic [1:0] pend_n;
	logic [POS_BITS-1:0] origin_n, start_sum;
	logic [FILL_BITS-1:0] fill_n, lead_ws_n, lead_sp_n, end_ws_n, end_sp_n, limit;
	logic [FILL_BITS-1:0] skip_sel, end_sel;
	logic seen_ws_n, seen_sp_n, seen_sel;

	always_comb begin
		b = item_s1.data_byte;
		last = item_s1.end_of_text;
		ws = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
		sp = (b == CH_SPACE);

		// codepoint tracking
		if (b[7:6] == 2'b10) begin
			pend_n = (pend_q != 2'd0) ? pend_q - 2'd1 : 2'd0;
		end else if (b[7:3] == 5'b11110) begin
			pend_n = 2'd3;
		end else if (b[7:4] == 4'b1110) begin
			pend_n = 2'd2;
		end else if (b[7:5] == 3'b110) begin
			pend_n = 2'd1;
		end else begin
			pend_n = 2'd0;
		end

		origin_n = (fill_q == '0) ? pos_q : origin_q;
		seen_ws_n = seen_ws_q || !ws;
		lead_ws_n = (!seen_ws_q && !ws) ? fill_q : lead_ws_q;
		end_ws_n = !ws ? fill_q + 7'd1 : end_ws_q;
		seen_sp_n = seen_sp_q || !sp;
		lead_sp_n = (!seen_sp_q && !sp) ? fill_q : lead_sp_q;
		end_sp_n = !sp ? fill_q + 7'd1 : end_sp_q;
		fill_n = fill_q + 7'd1;

		sep = (b == CH_DOT) || (b == CH_EXCL) || (b == CH_QUEST) || (b == CH_SEMI)
			|| (b == CH_LF)
			|| (recent_q[15:8] == CJK_A_B0 && recent_q[7:0] == CJK_A_B1 && b == CJK_STOP)
			|| (recent_q[15:8] == CJK_B_B0 && recent_q[7:0] == CJK_B_B1
				&& (b == CJK_EXCL || b == CJK_QUEST || b == CJK_SEMI));

		limit = (max_len_q > MAX_CAP) ? MAX_CAP : max_len_q;
		cut = !sep && (((fill_n >= limit) && (pend_n == 2'd0)) || (fill_n >= FILL_LIMIT));
		spaces_only = cut;
		close = sep || cut || last;
		has_result = close;

		seen_sel = spaces_only ? seen_sp_n : seen_ws_n;
		skip_sel = spaces_only ? lead_sp_n : lead_ws_n;
		end_sel = spaces_only ? end_sp_n : end_ws_n;
		start_sum = origin_n + POS_BITS'(skip_sel);

		result.text_done = last;
		if (seen_sel && (end_sel > skip_sel)) begin
			result.segment_valid = 1'b1;
			result.segment_start = START_BITS'(start_sum);
			result.segment_length = end_sel - skip_sel;
		end else begin
			result.segment_valid = 1'b0;
			result.segment_start = '0;
			result.segment_length = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			recent_q <= '0;
			pend_q <= '0;
			origin_q <= '0;
			fill_q <= '0;
			lead_ws_q <= '0;
			lead_sp_q <= '0;
			end_ws_q <= '0;
			end_sp_q <= '0;
			seen_ws_q <= 1'b0;
			seen_sp_q <= 1'b0;
		end else if (fire) begin
			pos_q <= last ? '0 : pos_q + POS_BITS'(1);
			recent_q <= last ? '0 : {recent_q[7:0], b};
			pend_q <= last ? 2'd0 : pend_n;
			if (close) begin
				origin_q <= '0;
				fill_q <= '0;
				lead_ws_q <= '0;
				lead_sp_q <= '0;
				end_ws_q <= '0;
				end_sp_q <= '0;
				seen_ws_q <= 1'b0;
				seen_sp_q <= 1'b0;
			end else begin
				origin_q <= origin_n;
				fill_q <= fill_n;
				lead_ws_q <= lead_ws_n;
				lead_sp_q <= lead_sp_n;
				end_ws_q <= end_ws_n;
				end_sp_q <= end_sp_n;
				seen_ws_q <= seen_ws_n;
				seen_sp_q <= seen_sp_n;
			end
		end
	end

	`USEG_ASSERT_IMPL(a_fill_below_limit, 1'b1, fill_q != FILL_LIMIT)
	`USEG_ASSERT_IMPL(a_ws_implies_sp, seen_ws_q, seen_sp_q)
	`USEG_ASSERT_IMPL(a_valid_nonempty, has_result && result.segment_valid, result.segment_length != '0)
	`USEG_ASSERT_NEXT(a_text_end_resets, fire && last, pos_q == '0 && fill_q == '0 && pend_q == 2'd0)

endmodule

>>> hw/rtl/utf8seg_out_stage.sv
module utf8seg_out_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  utf8seg_pkg::out_item_t result,
	input  logic out_stall,
	output logic out_free,
	output logic out_valid,
	output utf8seg_pkg::out_item_t out_data
);
	import utf8seg_pkg::*;

	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data <= result;
		end
	end

endmodule

>>> bench/tb.sv
module tb;
	import utf8seg_pkg::*;

	localparam int QUIET_LIMIT = 5000;   // cycles with no transfer before giving up
	localparam int SETTLE_CYCLES = 6;    // input reg + result reg, with margin
	localparam int PHASE_BYTES = 80;
	localparam int PHASE_COUNT = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [FILL_BITS-1:0] cfg_wdata = '0;

	// bytes waiting for the driver, segments waiting for the monitor
	in_item_t pending_bytes[$];
	out_item_t expected_segments[$];
	out_item_t oldest_segment;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int phase_bytes_queued;
	logic [FILL_BITS-1:0] phase_max_len;

	// opening text: leading blanks, every ascii and cjk separator, an all-blank
	// segment, byte extremes, trailing blank on the final byte
	logic [7:0] opening_text[25] = '{
		CH_SPACE, CH_TAB, 8'h41, CH_DOT,
		CH_EXCL,
		CH_SPACE, CH_QUEST,
		CH_CR, CH_LF,
		8'h00, CH_SEMI,
		CJK_A_B0, CJK_A_B1, CJK_STOP,
		CJK_B_B0, CJK_B_B1, CJK_EXCL,
		CJK_B_B0, CJK_B_B1, CJK_QUEST,
		CJK_B_B0, CJK_B_B1, CJK_SEMI,
		8'hFF, CH_SPACE
	};

	// settings per random phase; the last one is drawn at run time
	logic [FILL_BITS-1:0] max_len_plan[PHASE_COUNT] = '{
		7'd8, 7'd0, 7'd127, 7'd1, 7'd120, 7'd64, 7'd7, 7'd33
	};

	// segmenter state as the predictor sees it
	logic [FILL_BITS-1:0] max_len_cfg = MAX_LEN_RESET;
	logic [POS_BITS-1:0] text_pos = '0;
	logic [POS_BITS-1:0] seg_origin = '0;
	logic [FILL_BITS-1:0] seg_fill = '0;
	logic [FILL_BITS-1:0] lead_ws = '0;
	logic [FILL_BITS-1:0] lead_sp = '0;
	logic [FILL_BITS-1:0] end_ws = '0;
	logic [FILL_BITS-1:0] end_sp = '0;
	bit seen_ws = 1'b0;
	bit seen_sp = 1'b0;
	logic [15:0] last_two = '0;
	logic [1:0] cont_due = '0;

	utf8_sentence_segmenter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// trimmed view of the open segment; a hard cut trims spaces only
	function automatic out_item_t trimmed_segment(input bit spaces_only);
		out_item_t seg;
		logic [FILL_BITS-1:0] skip;
		logic [FILL_BITS-1:0] stop;
		bit seen;
		seg = '0;
		seen = spaces_only ? seen_sp : seen_ws;
		skip = spaces_only ? lead_sp : lead_ws;
		stop = spaces_only ? end_sp : end_ws;
		if (seen && stop > skip) begin
			seg.segment_valid = 1'b1;
			// wraps with the offset
			seg.segment_start = START_BITS'(seg_origin + POS_BITS'(skip));
			seg.segment_length = stop - skip;
		end
		return seg;
	endfunction

	function automatic void open_new_segment();
		seg_origin = '0;
		seg_fill = '0;
		lead_ws = '0;
		lead_sp = '0;
		end_ws = '0;
		end_sp = '0;
		seen_ws = 1'b0;
		seen_sp = 1'b0;
	endfunction

	// advance the predicted state by one accepted byte
	function automatic void predict_segment(input in_item_t item);
		logic [7:0] b;
		logic [FILL_BITS-1:0] cut_len;
		bit is_ws;
		bit is_sp;
		bit is_sep;
		bit closed;
		out_item_t seg;
		b = item.data_byte;
		cut_len = (max_len_cfg > MAX_CAP) ? MAX_CAP : max_len_cfg;
		is_ws = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
		is_sp = (b == CH_SPACE);

		// continuation bytes still owed by the current codepoint
		if (b[7:6] == 2'b10) begin
			if (cont_due != 2'd0)
				cont_due = cont_due - 2'd1;
		end else if (b[7:3] == 5'b11110) begin
			cont_due = 2'd3;
		end else if (b[7:4] == 4'b1110) begin
			cont_due = 2'd2;
		end else if (b[7:5] == 3'b110) begin
			cont_due = 2'd1;
		end else begin
			cont_due = 2'd0;
		end

		if (seg_fill == '0)
			seg_origin = text_pos;
		if (!is_ws) begin
			if (!seen_ws) begin
				seen_ws = 1'b1;
				lead_ws = seg_fill;
			end
			end_ws = seg_fill + 7'd1;
		end
		if (!is_sp) begin
			if (!seen_sp) begin
				seen_sp = 1'b1;
				lead_sp = seg_fill;
			end
			end_sp = seg_fill + 7'd1;
		end
		seg_fill = seg_fill + 7'd1;

		is_sep = (b == CH_DOT) || (b == CH_EXCL) || (b == CH_QUEST) || (b == CH_SEMI) ||
			(b == CH_LF);
		if (last_two == {CJK_A_B0, CJK_A_B1} && b == CJK_STOP)
			is_sep = 1'b1;
		if (last_two == {CJK_B_B0, CJK_B_B1} &&
				(b == CJK_EXCL || b == CJK_QUEST || b == CJK_SEMI))
			is_sep = 1'b1;
		last_two = {last_two[7:0], b};

		closed = 1'b0;
		seg = '0;
		if (is_sep) begin
			seg = trimmed_segment(1'b0);
			open_new_segment();
			closed = 1'b1;
		end else if ((seg_fill >= cut_len && cont_due == 2'd0) || seg_fill >= FILL_LIMIT) begin
			// hard cut, forced mid-codepoint only at the fill limit
			seg = trimmed_segment(1'b1);
			open_new_segment();
			closed = 1'b1;
		end

		if (item.end_of_text) begin
			if (!closed) begin
				seg = trimmed_segment(1'b0);
				open_new_segment();
			end
			seg.text_done = 1'b1;
			text_pos = '0;
			last_two = '0;
			cont_due = 2'd0;
			expected_segments.insert(expected_segments.size(), seg);
		end else begin
			text_pos = text_pos + POS_BITS'(1);
			if (closed)
				expected_segments.insert(expected_segments.size(), seg);
		end
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		in_item_t item;
		item.data_byte = b;
		item.end_of_text = 1'b0;
		pending_bytes.insert(pending_bytes.size(), item);
	endfunction

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(63));
	endfunction

	function automatic logic [7:0] letter_byte();
		return 8'($urandom_range(25)) + (($urandom_range(3) == 0) ? 8'h41 : 8'h61);
	endfunction

	// one text of at least target bytes, mostly well formed utf-8 with some noise;
	// returns the number of bytes queued
	function automatic int queue_text(input int target);
		int base;
		int kind;
		int n;
		base = pending_bytes.size();
		while (pending_bytes.size() - base < target) begin
			kind = $urandom_range(99);
			if (kind < 30) begin
				n = $urandom_range(10, 1);
				repeat (n) push_byte(letter_byte());
			end else if (kind < 50) begin
				case ($urandom_range(5))
					0: push_byte(CH_TAB);
					1: push_byte(CH_CR);
					2: push_byte(CH_LF);
					default: push_byte(CH_SPACE);
				endcase
			end else if (kind < 60) begin
				case ($urandom_range(3))
					0: push_byte(CH_DOT);
					1: push_byte(CH_EXCL);
					2: push_byte(CH_QUEST);
					default: push_byte(CH_SEMI);
				endcase
			end else if (kind < 68) begin
				push_byte(8'($urandom_range(8'hDF, 8'hC2)));
				push_byte(cont_byte());
			end else if (kind < 75) begin
				// cjk punctuation
				if ($urandom_range(3) == 0) begin
					push_byte(CJK_A_B0);
					push_byte(CJK_A_B1);
					push_byte(CJK_STOP);
				end else begin
					push_byte(CJK_B_B0);
					push_byte(CJK_B_B1);
					case ($urandom_range(2))
						0: push_byte(CJK_EXCL);
						1: push_byte(CJK_QUEST);
						default: push_byte(CJK_SEMI);
					endcase
				end
			end else if (kind < 81) begin
				// other three-byte codepoint, sometimes close to a cjk separator
				if ($urandom_range(3) == 0)
					push_byte($urandom_range(1) ? CJK_A_B0 : CJK_B_B0);
				else
					push_byte(8'($urandom_range(8'hE9, 8'hE4)));
				push_byte(cont_byte());
				push_byte(cont_byte());
			end else if (kind < 85) begin
				push_byte(8'($urandom_range(8'hF4, 8'hF0)));
				repeat (3) push_byte(cont_byte());
			end else if (kind < 90) begin
				push_byte(8'($urandom_range(255)));
			end else if (kind < 95) begin
				// clause with no separator, which can be long enough to reach a hard cut
				n = $urandom_range(25, 5);
				repeat (n) begin
					repeat ($urandom_range(10, 1)) push_byte(letter_byte());
					push_byte(CH_SPACE);
				end
			end else if (kind < 98) begin
				n = $urandom_range(130, 1);
				repeat (n) push_byte(($urandom_range(7) == 0) ? CH_TAB : CH_SPACE);
			end else begin
				// lead bytes only: no codepoint ever ends, so the fill limit cuts
				n = $urandom_range(140, 20);
				repeat (n) push_byte(8'($urandom_range(8'hF7, 8'hC0)));
			end
		end
		pending_bytes[pending_bytes.size() - 1].end_of_text = 1'b1;
		return pending_bytes.size() - base;
	endfunction

	// wait until every byte is sent and every segment is back, then let the pipe settle
	task automatic drain();
		while (pending_bytes.size() != 0 || in_valid || expected_segments.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// driver: a new byte only once the current transfer is done
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				predict_segment(in_data);
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					in_data <= pending_bytes.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result transfer with the oldest expected segment
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_segments.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected segment: valid=%0b start=%0d len=%0d done=%0b",
							out_data.segment_valid, out_data.segment_start,
							out_data.segment_length, out_data.text_done);
				end else begin
					oldest_segment = expected_segments.pop_front();
					if (out_data.segment_valid !== oldest_segment.segment_valid ||
							out_data.segment_start !== oldest_segment.segment_start ||
							out_data.segment_length !== oldest_segment.segment_length ||
							out_data.text_done !== oldest_segment.text_done) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"segment differs: expected valid=%0b start=%0d len=%0d",
								" done=%0b, got valid=%0b start=%0d len=%0d done=%0b"},
								oldest_segment.segment_valid, oldest_segment.segment_start,
								oldest_segment.segment_length, oldest_segment.text_done,
								out_data.segment_valid, out_data.segment_start,
								out_data.segment_length, out_data.text_done);
					end
				end
			end
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// opening text at the reset length
		foreach (opening_text[i])
			push_byte(opening_text[i]);
		pending_bytes[pending_bytes.size() - 1].end_of_text = 1'b1;
		drain();

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			// new max length while the block is idle
			phase_max_len = (phase == PHASE_COUNT - 1) ?
				FILL_BITS'($urandom_range(120, 8)) : max_len_plan[phase];
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= phase_max_len;
			@(posedge clk);
			cfg_we <= 1'b0;
			max_len_cfg = phase_max_len;

			// idle pattern: none, sender, receiver, both
			case (phase % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 81;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 81;
				end
				default: begin
					sender_idle_pct = 29;
					receiver_stall_pct = 29;
				end
			endcase

			phase_bytes_queued = 0;
			while (phase_bytes_queued < PHASE_BYTES)
				phase_bytes_queued += queue_text(($urandom_range(4) == 0) ?
					$urandom_range(300, 1) : $urandom_range(40, 1));
			drain();
		end

		if (mismatch_count == 0 && expected_segments.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> utf8_sentence_segmenter.f
+incdir+hw/rtl
hw/rtl/utf8seg_pkg.sv
hw/rtl/utf8seg_in_stage.sv
hw/rtl/utf8seg_core.sv
hw/rtl/utf8seg_out_stage.sv
hw/rtl/utf8_sentence_segmenter.sv
bench/tb.sv
